// File: sv/wepdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wepdec_pkg
// Shared constants and helper functions for the WEP-40 RC4 decryptor with
// CRC-32 ICV check.
// ----------------------------------------------------------------------------
package wepdec_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IV_W      = 24;
    localparam int unsigned KEY_W     = 40;
    localparam int unsigned CRC_W     = 32;
    localparam int unsigned KEY_BYTES = 8;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned FILL_W    = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    // Fold one byte into a reflected CRC-32, one bit per step
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Reverse byte order of a 32-bit word
    function automatic logic [CRC_W-1:0] byte_swap(input logic [CRC_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// File: sv/wep_rc4_decrypt_icv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wep_rc4_decrypt_icv_check
// Decrypts a WEP-40 frame body byte by byte with RC4 and checks the CRC-32
// ICV carried in the last four bytes of the body.
// ----------------------------------------------------------------------------
// An accepted beat passes the read-i, read-j, swap and output states before its
// result is loaded into the output register. A beat marked frame start first
// loads the identity permutation and runs the key schedule over 256 steps of
// read, read, write, write. A new byte is taken only in idle, after the previous
// one ends its read, read, swap and keystream read on the permutation memory.
// Reset (synchronous, active low) clears indices, CRC, window and key; the
// permutation memory has no reset and is loaded by the first frame start.
module wep_rc4_decrypt_icv_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wepdec_pkg::KEY_W-1:0]        i_cfg_data,     // wep_key
    // ciphertext input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [wepdec_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // iv[23:0], cipher_byte[31:24]
    input  logic                                s_axis_tuser,   // frame_start
    input  logic                                s_axis_tlast,   // last_byte
    // plaintext output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [wepdec_pkg::BYTE_W-1:0]       m_axis_tdata,   // plain_byte[7:0]
    output logic                                m_axis_tuser,   // icv_ok
    output logic                                m_axis_tlast    // frame_end
);
    import wepdec_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K_RDN,
        ST_K_RDJ,
        ST_K_WRN,
        ST_K_WRJ,
        ST_P_RDI,
        ST_P_RDJ,
        ST_P_SWP,
        ST_P_OUT
    } t_state;

    t_state              r_state;
    logic [KEY_W-1:0]    r_wep_key;
    logic [IV_W-1:0]     r_iv;
    logic [BYTE_W-1:0]   r_cb;
    logic                r_last;
    logic [BYTE_W-1:0]   r_n;
    logic [BYTE_W-1:0]   r_i;
    logic [BYTE_W-1:0]   r_j;
    logic [BYTE_W-1:0]   r_si;
    logic [BYTE_W-1:0]   r_sj;
    logic [CRC_W-1:0]    r_crc;
    logic [CRC_W-1:0]    r_win;
    logic [FILL_W-1:0]   r_fill;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;
    logic                r_out_last;
    logic                r_out_ok;

    // permutation memory, read data registered
    logic [BYTE_W-1:0]   mem [256];
    logic [BYTE_W-1:0]   r_rdata;
    logic                mem_rd_en;
    logic [BYTE_W-1:0]   mem_rd_addr;
    logic                mem_wr_en;
    logic [BYTE_W-1:0]   mem_wr_addr;
    logic [BYTE_W-1:0]   mem_wr_data;

    logic [BYTE_W-1:0]   key_arr [KEY_BYTES];
    logic [BYTE_W-1:0]   key_b;
    logic [BYTE_W-1:0]   n_i;
    logic [BYTE_W-1:0]   n_j;
    logic [BYTE_W-1:0]   ks_idx;
    logic [BYTE_W-1:0]   ks_byte;
    logic [BYTE_W-1:0]   plain;
    logic [CRC_W-1:0]    n_crc;
    logic [CRC_W-1:0]    n_win;
    logic [FILL_W-1:0]   n_fill;
    logic [CRC_W-1:0]    crc_fin;
    logic                icv_ok;
    logic                out_free;
    logic                in_beat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ok;

    // key schedule key: iv bytes first, then the five secret bytes
    assign key_arr[0] = r_iv[23:16];
    assign key_arr[1] = r_iv[15:8];
    assign key_arr[2] = r_iv[7:0];
    assign key_arr[3] = r_wep_key[39:32];
    assign key_arr[4] = r_wep_key[31:24];
    assign key_arr[5] = r_wep_key[23:16];
    assign key_arr[6] = r_wep_key[15:8];
    assign key_arr[7] = r_wep_key[7:0];
    assign key_b      = key_arr[r_n[2:0]];

    // index arithmetic for key schedule and keystream
    assign n_i    = r_i + 8'd1;
    assign n_j    = (r_state == ST_K_RDJ) ? (r_j + r_rdata + key_b) : (r_j + r_rdata);
    assign ks_idx = r_si + r_sj;

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_n;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_n;
        mem_wr_data = r_n;
        unique case (r_state)
            ST_INIT: begin
                mem_wr_en = 1'b1;
            end
            ST_K_RDN: begin
                mem_rd_en = 1'b1;
            end
            ST_K_RDJ, ST_P_RDJ: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = n_j;
            end
            ST_K_WRN: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = r_rdata;
            end
            ST_K_WRJ, ST_P_OUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_j;
                mem_wr_data = r_si;
            end
            ST_P_RDI: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = n_i;
            end
            ST_P_SWP: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_si + r_rdata;
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_i;
                mem_wr_data = r_rdata;
            end
            default: begin
            end
        endcase
    end

    // permutation storage, read-first
    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rdata <= mem[mem_rd_addr];
        end
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // forward the swapped entries to the keystream read; S[j] is written last
    always_comb begin
        if (ks_idx == r_j) begin
            ks_byte = r_si;
        end else if (ks_idx == r_i) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = r_rdata;
        end
    end

    // decrypt, advance the ICV window and CRC
    assign plain   = r_cb ^ ks_byte;
    assign n_crc   = r_fill[2] ? crc_byte(r_crc, r_win[31:24]) : r_crc;
    assign n_win   = {r_win[23:0], plain};
    assign n_fill  = r_fill[2] ? r_fill : r_fill + 3'd1;
    assign crc_fin = n_crc ^ CRC_INIT;
    assign icv_ok  = r_last && n_fill[2] && (n_win == byte_swap(crc_fin));

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wep_key   <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_crc       <= CRC_INIT;
            r_win       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wep_key <= i_cfg_data;
            end
            // drop the taken result unless the output step loads a new one
            if (r_out_valid && m_axis_tready && (r_state != ST_P_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_iv   <= s_axis_tdata[23:0];
                        r_cb   <= s_axis_tdata[31:24];
                        r_last <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_crc   <= CRC_INIT;
                            r_win   <= '0;
                            r_fill  <= '0;
                            r_n     <= '0;
                            r_j     <= '0;
                            r_state <= ST_INIT;
                        end else begin
                            r_state <= ST_P_RDI;
                        end
                    end
                end
                // load the identity permutation
                ST_INIT: begin
                    r_n <= r_n + 8'd1;
                    if (r_n == 8'hFF) begin
                        r_state <= ST_K_RDN;
                    end
                end
                ST_K_RDN: begin
                    r_state <= ST_K_RDJ;
                end
                ST_K_RDJ: begin
                    r_si    <= r_rdata;
                    r_j     <= n_j;
                    r_state <= ST_K_WRN;
                end
                ST_K_WRN: begin
                    r_state <= ST_K_WRJ;
                end
                ST_K_WRJ: begin
                    r_n <= r_n + 8'd1;
                    if (r_n == 8'hFF) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_P_RDI;
                    end else begin
                        r_state <= ST_K_RDN;
                    end
                end
                // keystream generation
                ST_P_RDI: begin
                    r_i     <= n_i;
                    r_state <= ST_P_RDJ;
                end
                ST_P_RDJ: begin
                    r_si    <= r_rdata;
                    r_j     <= n_j;
                    r_state <= ST_P_SWP;
                end
                ST_P_SWP: begin
                    r_sj    <= r_rdata;
                    r_state <= ST_P_OUT;
                end
                // hold until the output register is free
                ST_P_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= plain;
                        r_out_last  <= r_last;
                        r_out_ok    <= icv_ok;
                        if (r_last) begin
                            r_crc  <= CRC_INIT;
                            r_win  <= '0;
                            r_fill <= '0;
                        end else begin
                            r_crc  <= n_crc;
                            r_win  <= n_win;
                            r_fill <= n_fill;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // icv_ok is only ever reported on a frame end
    a_ok_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("icv_ok without frame_end");

    // a new result is loaded only from the keystream output step
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_P_OUT))
        else $error("result loaded outside keystream step");

    // the keystream output step ends in idle or holds
    a_out_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_P_OUT |=> r_state == ST_IDLE || r_state == ST_P_OUT)
        else $error("bad exit from keystream output step");

    // the window fill never passes four
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[2] |-> r_fill[1:0] == 2'd0)
        else $error("window fill overflow");

endmodule
